// ===== design/tile_sprite_scanline_compositor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scanline compositor
// Two forms: an implication checked in the same cycle and one checked in the
// cycle after. Both are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TILE_SPRITE_SCANLINE_COMPOSITOR_ASSERT_SVH
`define TILE_SPRITE_SCANLINE_COMPOSITOR_ASSERT_SVH

// check the consequent in the cycle of the antecedent
`define TSSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check the consequent in the cycle after the antecedent
`define TSSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tssc_pkg.sv =====
// ----------------------------------------------------------------------------
// tssc_pkg
// Types and fixed constants shared by the scanline compositor modules.
// ----------------------------------------------------------------------------
package tssc_pkg;

  localparam int TILE_W    = 8;   // pixels in one tile row
  localparam int NUM_LANES = TILE_W;
  localparam int LANE_W    = 3;   // bits to number a pixel within a tile row
  localparam int COLOR_W   = 6;
  localparam int PIX_W     = COLOR_W + 1;  // opaque flag above the color
  localparam int OPAQUE_B  = PIX_W - 1;
  localparam int NUM_LINES = 3;
  localparam int LINE_FRONT = 0;
  localparam int LINE_BG    = 1;
  localparam int LINE_BACK  = 2;
  localparam int PAL_BANKS = 4;   // entries of one subpalette, one per bank
  localparam int PAL_ROWS  = 8;   // subpalettes
  localparam int PAL_AW    = 3;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_BG     = 3'd1,
    MODE_SPRITE = 3'd2,
    MODE_PAL    = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_READ,
    ST_CLEAR
  } state_t;

  // tile row held while the lanes draw it
  typedef struct packed {
    logic [8:0]           x0;       // two's complement
    logic [7:0]           lo;
    logic [7:0]           hi;
    logic                 mirror;
    logic [NUM_LINES-1:0] line_sel;
  } row_t;

  typedef struct packed {
    logic draw;
    logic clear;
    logic read;
  } lane_ctl_t;

endpackage

// ===== design/tssc_ram.sv =====
// ----------------------------------------------------------------------------
// tssc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tssc_lane.sv =====
// ----------------------------------------------------------------------------
// tssc_lane
// One pixel bank of all three line buffers: every pixel x with x mod 8 equal
// to LANE. Draws the one tile pixel that lands in this bank, clears and reads back.
// ----------------------------------------------------------------------------
module tssc_lane import tssc_pkg::*; #(
  parameter int LANE       = 0,
  parameter int LINE_WIDTH = 256,
  parameter int ROW_AW     = 5
) (
  input  logic                                 clk,
  input  lane_ctl_t                            ctl,
  input  row_t                                 row,
  input  logic [PAL_BANKS-1:1][COLOR_W-1:0]    pal,
  input  logic [ROW_AW-1:0]                    clr_addr,
  input  logic [ROW_AW-1:0]                    rd_addr,
  output logic [NUM_LINES-1:0][PIX_W-1:0]      rdata
);

  localparam int ROWS = 1 << ROW_AW;

  logic [LANE_W-1:0]    tap;
  logic [LANE_W-1:0]    bit_sel;
  logic [9:0]           px;
  logic                 on_line;
  logic [1:0]           pix_val;
  logic [COLOR_W-1:0]   color;
  logic [15:0]          px_row;
  logic [ROW_AW-1:0]    waddr;
  logic [PIX_W-1:0]     wdata;
  logic [NUM_LINES-1:0] we;

  always_comb begin
    // which pixel of the tile row falls into this bank
    tap     = LANE_W'(LANE) - row.x0[LANE_W-1:0];
    bit_sel = row.mirror ? tap : ~tap;
    px      = {row.x0[8], row.x0} + {7'd0, tap};
    on_line = !px[9] && ({1'b0, px} < 11'(LINE_WIDTH));
    pix_val = {row.hi[bit_sel], row.lo[bit_sel]};
    case (pix_val)
      2'd1:    color = pal[1];
      2'd2:    color = pal[2];
      2'd3:    color = pal[3];
      default: color = '0;
    endcase
    px_row = 16'(px[9:3]);
    waddr  = ctl.clear ? clr_addr : px_row[ROW_AW-1:0];
    wdata  = ctl.clear ? '0 : {1'b1, color};
    for (int k = 0; k < NUM_LINES; k++) begin
      we[k] = ctl.clear ||
              (ctl.draw && row.line_sel[k] && (pix_val != 2'd0) && on_line);
    end
  end

  for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
    tssc_ram #(
      .WIDTH(PIX_W),
      .DEPTH(ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (we[k]),
      .waddr(waddr),
      .wdata(wdata),
      .re   (ctl.read),
      .raddr(rd_addr),
      .rdata(rdata[k])
    );
  end

endmodule

// ===== design/tssc_merge.sv =====
// ----------------------------------------------------------------------------
// tssc_merge
// Picks the read pixel's bank out of the lanes and applies the priority:
// front sprite, background, back sprite, then the backdrop color.
// ----------------------------------------------------------------------------
module tssc_merge import tssc_pkg::*; (
  input  logic [NUM_LANES-1:0][NUM_LINES-1:0][PIX_W-1:0] line_q,
  input  logic [LANE_W-1:0]                              bank,
  input  logic                                           in_range,
  input  logic [COLOR_W-1:0]                             backdrop,
  output logic [COLOR_W-1:0]                             color
);

  logic [NUM_LINES-1:0][PIX_W-1:0] pix;

  always_comb begin
    pix   = line_q[bank];
    color = backdrop;
    if (in_range) begin
      if (pix[LINE_FRONT][OPAQUE_B]) begin
        color = pix[LINE_FRONT][COLOR_W-1:0];
      end else if (pix[LINE_BG][OPAQUE_B]) begin
        color = pix[LINE_BG][COLOR_W-1:0];
      end else if (pix[LINE_BACK][OPAQUE_B]) begin
        color = pix[LINE_BACK][COLOR_W-1:0];
      end
    end
  end

endmodule

// ===== design/tile_sprite_scanline_compositor.sv =====
// ----------------------------------------------------------------------------
// tile_sprite_scanline_compositor
// Palette RAM plus front sprite, background and back sprite line buffers,
// each split into eight pixel banks so a whole tile row is drawn in a
// single write. A tile row is drawn by first reading the subpalette from
// the palette banks, then having the eight lanes write their pixels. A
// pixel read first reads the line banks and the backdrop entry, then
// merges them into the result register once that register is not stalled.
// A clear, and the pass that follows reset, sweeps the banks one row a
// cycle, during which no item is taken; the pass after reset also zeroes
// the palette.
// ----------------------------------------------------------------------------
`include "tile_sprite_scanline_compositor_assert.svh"

module tile_sprite_scanline_compositor import tssc_pkg::*; #(
  parameter int LINE_WIDTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [2:0]         mode,
  input  logic signed [8:0]  x_pos,
  input  logic [7:0]         plane_low,
  input  logic [7:0]         plane_high,
  input  logic [1:0]         palette_select,
  input  logic               flip_x,
  input  logic               behind_background,
  input  logic [4:0]         palette_addr,
  input  logic [5:0]         color_value,
  input  logic [7:0]         read_x,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [5:0]         pixel_color
);

  localparam int LINE_ROWS  = (LINE_WIDTH + TILE_W - 1) / TILE_W;
  localparam int ROW_AW     = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
  localparam int LINE_DEPTH = 1 << ROW_AW;
  localparam int SWEEP_LEN  = (LINE_DEPTH > PAL_ROWS) ? LINE_DEPTH : PAL_ROWS;
  localparam int CNT_W      = $clog2(SWEEP_LEN);

  state_t             state, state_next;
  logic [CNT_W-1:0]   clr_cnt, clr_cnt_next;
  logic               pal_clear, pal_clear_next;
  logic               result_valid_next;
  logic               accept;
  logic               out_load;
  logic               clr_last;
  logic               line_clr_en;
  logic               pal_clr_en;

  row_t               row;
  row_t               row_in;
  logic [LANE_W-1:0]  rd_bank;
  logic               rd_in_range;
  logic [15:0]        rd_row_wide;
  lane_ctl_t          lane_ctl;

  logic [PAL_BANKS-1:0]              pal_we;
  logic [PAL_AW-1:0]                 pal_waddr;
  logic [COLOR_W-1:0]                pal_wdata;
  logic                              pal_re;
  logic [PAL_AW-1:0]                 pal_raddr;
  logic [PAL_BANKS-1:0][COLOR_W-1:0] pal_q;

  logic [NUM_LANES-1:0][NUM_LINES-1:0][PIX_W-1:0] line_q;
  logic [COLOR_W-1:0]                             merge_color;

  assign clr_last    = (clr_cnt == CNT_W'(SWEEP_LEN - 1));
  assign line_clr_en = ({1'b0, clr_cnt} < (CNT_W + 1)'(LINE_DEPTH));
  assign pal_clr_en  = pal_clear && ({1'b0, clr_cnt} < (CNT_W + 1)'(PAL_ROWS));

  // next state
  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    pal_clear_next = pal_clear;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode_t'(mode))
            MODE_CLEAR: begin
              state_next     = ST_CLEAR;
              clr_cnt_next   = '0;
              pal_clear_next = 1'b0;
            end
            MODE_BG, MODE_SPRITE: state_next = ST_ROW;
            MODE_READ:            state_next = ST_READ;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_ROW: begin
        state_next = ST_IDLE;
      end
      ST_READ: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_last) begin
          state_next     = ST_IDLE;
          pal_clear_next = 1'b0;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    item_stall = (state != ST_IDLE);
    accept     = item_valid && !item_stall;
    out_load   = (state == ST_READ) && (!result_valid || !result_stall);
    result_valid_next = out_load || (result_valid && result_stall);

    row_in.x0       = x_pos;
    row_in.lo       = plane_low;
    row_in.hi       = plane_high;
    row_in.mirror   = (mode == MODE_SPRITE) && flip_x;
    row_in.line_sel = '0;
    if (mode == MODE_BG) begin
      row_in.line_sel[LINE_BG] = 1'b1;
    end else if (behind_background) begin
      row_in.line_sel[LINE_BACK] = 1'b1;
    end else begin
      row_in.line_sel[LINE_FRONT] = 1'b1;
    end

    rd_row_wide    = 16'(read_x[7:3]);
    lane_ctl.draw  = (state == ST_ROW);
    lane_ctl.clear = (state == ST_CLEAR) && line_clr_en;
    lane_ctl.read  = accept && (mode == MODE_READ);

    // palette: zero pass after reset, else one entry per write
    for (int b = 0; b < PAL_BANKS; b++) begin
      pal_we[b] = ((state == ST_CLEAR) && pal_clr_en) ||
                  (accept && (mode == MODE_PAL) && (palette_addr[1:0] == 2'(b)));
    end
    pal_waddr = (state == ST_CLEAR) ? clr_cnt[PAL_AW-1:0] : palette_addr[4:2];
    pal_wdata = (state == ST_CLEAR) ? '0 : color_value;
    pal_re    = accept && ((mode == MODE_BG) || (mode == MODE_SPRITE) ||
                           (mode == MODE_READ));
    pal_raddr = (mode == MODE_READ) ? '0 : {mode == MODE_SPRITE, palette_select};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      pal_clear    <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr_cnt      <= clr_cnt_next;
      pal_clear    <= pal_clear_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row         <= row_in;
      rd_bank     <= read_x[LANE_W-1:0];
      rd_in_range <= ({3'b000, read_x} < 11'(LINE_WIDTH));
    end
    if (out_load) begin
      pixel_color <= merge_color;
    end
  end

  for (genvar b = 0; b < PAL_BANKS; b++) begin : g_pal
    tssc_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(PAL_ROWS)
    ) u_pal (
      .clk  (clk),
      .we   (pal_we[b]),
      .waddr(pal_waddr),
      .wdata(pal_wdata),
      .re   (pal_re),
      .raddr(pal_raddr),
      .rdata(pal_q[b])
    );
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tssc_lane #(
      .LANE      (g),
      .LINE_WIDTH(LINE_WIDTH),
      .ROW_AW    (ROW_AW)
    ) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .row     (row),
      .pal     (pal_q[PAL_BANKS-1:1]),
      .clr_addr(clr_cnt[ROW_AW-1:0]),
      .rd_addr (rd_row_wide[ROW_AW-1:0]),
      .rdata   (line_q[g])
    );
  end

  tssc_merge u_merge (
    .line_q  (line_q),
    .bank    (rd_bank),
    .in_range(rd_in_range),
    .backdrop(pal_q[0]),
    .color   (merge_color)
  );

  `TSSC_ASSERT_NEXT(a_read_enters_merge, clk, rst, accept && (mode == MODE_READ), state == ST_READ, "pixel read did not reach merge")
  `TSSC_ASSERT_NEXT(a_row_single_write, clk, rst, state == ST_ROW, state == ST_IDLE, "tile row draw did not finish in one cycle")
  `TSSC_ASSERT_NEXT(a_clear_starts, clk, rst, accept && (mode == MODE_CLEAR), (state == ST_CLEAR) && (clr_cnt == '0) && !pal_clear, "clear sweep started wrong")
  `TSSC_ASSERT_NEXT(a_result_loaded, clk, rst, (state == ST_READ) && !(result_valid && result_stall), result_valid, "merged pixel not loaded into result register")

endmodule
